### rtl/aob_pkg.sv
// ----------------------------------------------------------------------------
// aob_pkg
// Shared types, constants and the rounded 8-bit fraction multiply used by the
// alpha-over blend pipeline.
// ----------------------------------------------------------------------------
package aob_pkg;

  localparam int unsigned PixW = 8;

  // pipeline stage map
  localparam int unsigned NumStages        = 7;
  localparam int unsigned DivFirst         = 2;
  localparam int unsigned DivLast          = 5;
  localparam int unsigned OutStage         = 6;
  localparam int unsigned DivStepsPerStage = 2;

  localparam logic [2*PixW:0] RoundBias = 17'h00080;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = PixW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CEL_ALPHA   = 1'b0,
    CFG_LAYER_ALPHA = 1'b1
  } aob_cfg_idx_e;

  typedef logic [PixW-1:0] pix_t;

  // per-stage enables and valid bits
  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } aob_pipe_ctrl_t;

  // one colour channel entering the divider
  typedef struct packed {
    logic [2*PixW-1:0] prod_mag;
    logic              neg;
    pix_t              dst;
  } aob_chan_t;

  // rounded product of two 8-bit fractions
  function automatic pix_t rmul8(input pix_t a, input pix_t b);
    logic [2*PixW:0] t;
    logic [2*PixW:0] u;
    t = ({{(PixW+1){1'b0}}, a} * {{(PixW+1){1'b0}}, b}) + RoundBias;
    u = (t >> PixW) + t;
    return u[2*PixW-1:PixW];
  endfunction

endpackage

### rtl/aob_pix_in_if.sv
// ----------------------------------------------------------------------------
// aob_pix_in_if
// Source and destination RGBA pixel channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface aob_pix_in_if;

  logic       valid;
  logic       ready;
  logic [7:0] src_red;
  logic [7:0] src_green;
  logic [7:0] src_blue;
  logic [7:0] src_alpha;
  logic [7:0] dst_red;
  logic [7:0] dst_green;
  logic [7:0] dst_blue;
  logic [7:0] dst_alpha;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
    output dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );

  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
    input  dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );

endinterface

### rtl/aob_pix_out_if.sv
// ----------------------------------------------------------------------------
// aob_pix_out_if
// Blended RGBA pixel channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface aob_pix_out_if;

  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );

endinterface

### rtl/aob_alpha.sv
// ----------------------------------------------------------------------------
// aob_alpha
// First two pipeline stages: effective source alpha, channel differences,
// result alpha and the products that feed the channel dividers.
// ----------------------------------------------------------------------------
module aob_alpha (
  input  logic                        clk_i,
  input  aob_pkg::aob_pipe_ctrl_t     ctrl_i,
  input  aob_pkg::pix_t               opacity_i,
  input  aob_pkg::pix_t               src_red_i,
  input  aob_pkg::pix_t               src_green_i,
  input  aob_pkg::pix_t               src_blue_i,
  input  aob_pkg::pix_t               src_alpha_i,
  input  aob_pkg::pix_t               dst_red_i,
  input  aob_pkg::pix_t               dst_green_i,
  input  aob_pkg::pix_t               dst_blue_i,
  input  aob_pkg::pix_t               dst_alpha_i,
  output aob_pkg::aob_chan_t [2:0]    chan_o,
  output aob_pkg::pix_t               ra_o,
  output logic                        pass_o,
  output aob_pkg::pix_t               alpha_o
);
  import aob_pkg::*;

  pix_t       src_c [3];
  pix_t       dst_c [3];

  // stage 0
  pix_t       sa_d, sa_q;
  logic       pass0_d, pass0_q;
  pix_t       da0_q;
  pix_t       dmag_d [3];
  pix_t       dmag_q [3];
  logic [2:0] neg0_d, neg0_q;
  pix_t       dst0_q [3];

  // stage 1
  logic [PixW:0] ra_w;
  pix_t          ra1_d, ra1_q;
  logic          pass1_d, pass1_q;
  pix_t          alpha1_d, alpha1_q;
  aob_chan_t [2:0] chan1_d, chan1_q;

  always_comb begin
    src_c[0] = src_red_i;
    src_c[1] = src_green_i;
    src_c[2] = src_blue_i;
    dst_c[0] = dst_red_i;
    dst_c[1] = dst_green_i;
    dst_c[2] = dst_blue_i;
  end

  // effective source alpha and channel difference magnitudes
  always_comb begin
    sa_d    = rmul8(src_alpha_i, opacity_i);
    pass0_d = (opacity_i == '0) || (src_alpha_i == '0);
    for (int c = 0; c < 3; c++) begin
      neg0_d[c]  = src_c[c] < dst_c[c];
      dmag_d[c]  = neg0_d[c] ? (dst_c[c] - src_c[c]) : (src_c[c] - dst_c[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[0]) begin
      sa_q    <= sa_d;
      pass0_q <= pass0_d;
      da0_q   <= dst_alpha_i;
      neg0_q  <= neg0_d;
      for (int c = 0; c < 3; c++) begin
        dmag_q[c] <= dmag_d[c];
        dst0_q[c] <= dst_c[c];
      end
    end
  end

  // result alpha and scaled differences
  always_comb begin
    ra_w     = {1'b0, da0_q} + {1'b0, sa_q} - {1'b0, rmul8(da0_q, sa_q)};
    ra1_d    = ra_w[PixW-1:0];
    pass1_d  = pass0_q || (ra1_d == '0);
    alpha1_d = pass1_d ? da0_q : ra1_d;
    for (int c = 0; c < 3; c++) begin
      chan1_d[c].prod_mag = {{PixW{1'b0}}, dmag_q[c]} * {{PixW{1'b0}}, sa_q};
      chan1_d[c].neg      = neg0_q[c];
      chan1_d[c].dst      = dst0_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      ra1_q    <= ra1_d;
      pass1_q  <= pass1_d;
      alpha1_q <= alpha1_d;
      chan1_q  <= chan1_d;
    end
  end

  assign chan_o  = chan1_q;
  assign ra_o    = ra1_q;
  assign pass_o  = pass1_q;
  assign alpha_o = alpha1_q;

endmodule

### rtl/aob_div_lane.sv
// ----------------------------------------------------------------------------
// aob_div_lane
// One colour channel: pipelined restoring divide of |s-d|*sa by ra, two
// quotient bits per stage, then sign and add to the destination value.
// ----------------------------------------------------------------------------
module aob_div_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  aob_pkg::aob_pipe_ctrl_t ctrl_i,
  input  aob_pkg::aob_chan_t      chan_i,
  input  aob_pkg::pix_t           ra_i,
  input  logic                    pass_i,
  output aob_pkg::pix_t           out_o
);
  import aob_pkg::*;

  // partial remainder in the upper half, dividend bits / quotient below
  logic [2*PixW-1:0] w_d   [DivFirst:DivLast];
  logic [2*PixW-1:0] w_q   [DivFirst:DivLast];
  logic              neg_q [DivFirst:DivLast];
  pix_t              dst_q [DivFirst:DivLast];
  pix_t              ra_q  [DivFirst:DivLast];
  logic              pass_q[DivFirst:DivLast];

  pix_t quot;
  pix_t sum;
  pix_t out_d, out_q;

  // one restoring step: shift in a dividend bit, subtract if it fits
  function automatic logic [2*PixW-1:0] div_step(input logic [2*PixW-1:0] w,
                                                 input pix_t ra);
    logic [PixW:0] r;
    logic          qb;
    r  = {w[2*PixW-1:PixW], w[PixW-1]};
    qb = r >= {1'b0, ra};
    if (qb) begin
      r = r - {1'b0, ra};
    end
    return {r[PixW-1:0], w[PixW-2:0], qb};
  endfunction

  for (genvar s = DivFirst; s <= DivLast; s++) begin : g_div
    logic [2*PixW-1:0] w_in;
    logic              neg_in;
    pix_t              dst_in;
    pix_t              ra_in;
    logic              pass_in;

    if (s == DivFirst) begin : g_head
      assign w_in    = chan_i.prod_mag;
      assign neg_in  = chan_i.neg;
      assign dst_in  = chan_i.dst;
      assign ra_in   = ra_i;
      assign pass_in = pass_i;
    end else begin : g_body
      assign w_in    = w_q[s-1];
      assign neg_in  = neg_q[s-1];
      assign dst_in  = dst_q[s-1];
      assign ra_in   = ra_q[s-1];
      assign pass_in = pass_q[s-1];
    end

    always_comb begin
      w_d[s] = w_in;
      for (int k = 0; k < DivStepsPerStage; k++) begin
        w_d[s] = div_step(w_d[s], ra_in);
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en[s]) begin
        w_q[s]    <= w_d[s];
        neg_q[s]  <= neg_in;
        dst_q[s]  <= dst_in;
        ra_q[s]   <= ra_in;
        pass_q[s] <= pass_in;
      end
    end
  end

  // apply sign, add to destination
  always_comb begin
    quot  = w_q[DivLast][PixW-1:0];
    sum   = neg_q[DivLast] ? (dst_q[DivLast] - quot) : (dst_q[DivLast] + quot);
    out_d = pass_q[DivLast] ? dst_q[DivLast] : sum;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[OutStage]) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

`ifndef SYNTHESIS
  // partial remainder always stays below the divisor
  a_rem_bound_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.vld[DivFirst] && !pass_q[DivFirst]) |->
      (w_q[DivFirst][2*PixW-1:PixW] < ra_q[DivFirst]))
    else $error("divider remainder out of range at first stage");

  a_rem_bound_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.vld[DivLast] && !pass_q[DivLast]) |->
      (w_q[DivLast][2*PixW-1:PixW] < ra_q[DivLast]))
    else $error("divider remainder out of range at last stage");
`endif

endmodule

### rtl/alpha_over_blend_8bit.sv
// ----------------------------------------------------------------------------
// alpha_over_blend_8bit
// Normal-mode compositing of a non-premultiplied RGBA source pixel over a
// destination pixel, scaled by cel and layer opacity.
//
//   port    dir   kind           content
//   pix_i   in    valid/ready    source RGBA and destination RGBA
//   pix_o   out   valid/ready    blended RGBA
//   cfg_*   in    write only     index 0 cel alpha, index 1 layer alpha
//
// One pixel per clock sustained while pix_o is ready; the datapath has seven
// stages (two alpha stages, four divider stages at two quotient bits each, one
// output stage).
// Reset clears all valid bits and sets both opacities to 255.
// A stalled output holds only as many stages as are full; empty stages keep
// accepting, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module alpha_over_blend_8bit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [aob_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [aob_pkg::CfgDataW-1:0] cfg_wdata_i,
  aob_pix_in_if.sink                   pix_i,
  aob_pix_out_if.source                pix_o
);
  import aob_pkg::*;

  pix_t cel_q;
  pix_t layer_q;
  pix_t opacity_q;

  logic [NumStages-1:0] en;
  logic [NumStages-1:0] vld_d, vld_q;
  aob_pipe_ctrl_t       ctrl;

  aob_chan_t [2:0] chan;
  pix_t            ra;
  logic            pass;
  pix_t            alpha;
  pix_t            alpha_q [DivFirst:OutStage];
  pix_t            lane_out [3];

  // configuration registers, opacity product kept alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cel_q     <= '1;
      layer_q   <= '1;
      opacity_q <= '1;
    end else if (cfg_we_i) begin
      unique case (aob_cfg_idx_e'(cfg_idx_i))
        CFG_CEL_ALPHA: begin
          cel_q     <= cfg_wdata_i[PixW-1:0];
          opacity_q <= rmul8(cfg_wdata_i[PixW-1:0], layer_q);
        end
        CFG_LAYER_ALPHA: begin
          layer_q   <= cfg_wdata_i[PixW-1:0];
          opacity_q <= rmul8(cel_q, cfg_wdata_i[PixW-1:0]);
        end
      endcase
    end
  end

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || pix_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = pix_i.valid;
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign ctrl.en  = en;
  assign ctrl.vld = vld_q;

  aob_alpha u_alpha (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .opacity_i   (opacity_q),
    .src_red_i   (pix_i.src_red),
    .src_green_i (pix_i.src_green),
    .src_blue_i  (pix_i.src_blue),
    .src_alpha_i (pix_i.src_alpha),
    .dst_red_i   (pix_i.dst_red),
    .dst_green_i (pix_i.dst_green),
    .dst_blue_i  (pix_i.dst_blue),
    .dst_alpha_i (pix_i.dst_alpha),
    .chan_o      (chan),
    .ra_o        (ra),
    .pass_o      (pass),
    .alpha_o     (alpha)
  );

  // one divider lane per colour channel
  for (genvar c = 0; c < 3; c++) begin : g_lane
    aob_div_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .chan_i (chan[c]),
      .ra_i   (ra),
      .pass_i (pass),
      .out_o  (lane_out[c])
    );
  end

  // result alpha rides along with the divider and output stages
  for (genvar s = DivFirst; s <= OutStage; s++) begin : g_alpha_line
    if (s == DivFirst) begin : g_head
      always_ff @(posedge clk_i) begin
        if (en[s]) begin
          alpha_q[s] <= alpha;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (en[s]) begin
          alpha_q[s] <= alpha_q[s-1];
        end
      end
    end
  end

  assign pix_i.ready     = en[0];
  assign pix_o.valid     = vld_q[NumStages-1];
  assign pix_o.out_red   = lane_out[0];
  assign pix_o.out_green = lane_out[1];
  assign pix_o.out_blue  = lane_out[2];
  assign pix_o.out_alpha = alpha_q[OutStage];

`ifndef SYNTHESIS
  // opacity register always matches the two opacity settings
  a_opacity_sync : assert property (@(posedge clk_i) disable iff (!rst_ni)
    opacity_q == rmul8(cel_q, layer_q))
    else $error("opacity register out of step with cel and layer alpha");

  // a full stage that is held keeps its transaction
  a_stall_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((vld_q & $past(vld_q & ~en)) == $past(vld_q & ~en)))
    else $error("stalled pipeline stage lost its transaction");

  // an accepted transaction lands in the first stage
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> vld_q[0])
    else $error("accepted transaction missing from first stage");
`endif

endmodule

### sim/tb_alpha_over_blend_8bit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alpha_over_blend_8bit
// Drives RGBA source/destination pixel pairs into the alpha-over blender and
// checks every blended pixel against a behavioral predictor of the
// unpremultiplied over operator. Covers corner pixels, zero opacity, effective
// alpha rounding to zero, a long output stall, and random pixels under a range
// of cel and layer opacities with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_alpha_over_blend_8bit;

  import aob_pkg::*;

  localparam int unsigned ClkHalf      = 6;
  localparam int unsigned ResetCycles  = 8;
  localparam int unsigned DrainCycles  = 12;
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned PhaseItems   = 120;
  localparam int unsigned NumPhases    = 9;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned PressureItems = 40;

  // one source/destination pixel pair
  typedef struct packed {
    pix_t src_red;
    pix_t src_green;
    pix_t src_blue;
    pix_t src_alpha;
    pix_t dst_red;
    pix_t dst_green;
    pix_t dst_blue;
    pix_t dst_alpha;
  } blend_in_t;

  // one blended pixel
  typedef struct packed {
    pix_t out_red;
    pix_t out_green;
    pix_t out_blue;
    pix_t out_alpha;
  } blend_out_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  aob_pix_in_if  pix_in();
  aob_pix_out_if pix_out();

  alpha_over_blend_8bit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_in),
    .pix_o       (pix_out)
  );

  // shadow of the opacity registers
  pix_t cel_opacity;
  pix_t layer_opacity;

  blend_out_t blend_expected_q[$];

  bit tx_idle_en;
  bit rx_idle_en;
  int rx_hold_left;
  int rx_stall_left;
  int err_count;
  int pixels_sent;
  int pixels_checked;
  int opacity_settings;
  int input_stall_cycles;
  int unsigned cycle_cnt;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // cycle count and input stall count
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && pix_in.valid && !pix_in.ready) begin
      input_stall_cycles <= input_stall_cycles + 1;
    end
  end

  // run limit
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("tb_alpha_over_blend_8bit: errors");
    $finish;
  end

  // rounded product of two 8-bit fractions
  function automatic pix_t frac_mul(input pix_t a, input pix_t b);
    logic [16:0] t;
    t = a * b + 17'h80;
    t = t + (t >> 8);
    return t[15:8];
  endfunction

  // one colour channel, signed quotient truncated toward zero
  function automatic pix_t blend_chan(input pix_t s, input pix_t d, input pix_t sa,
                                      input int ra);
    int diff;
    int q;
    int sum;
    diff = int'(s) - int'(d);
    q = (diff * int'(sa)) / ra;
    sum = int'(d) + q;
    return sum[7:0];
  endfunction

  function automatic blend_out_t predict_blend(input blend_in_t px);
    pix_t opacity;
    pix_t sa;
    int ra;
    blend_out_t res;
    res.out_red   = px.dst_red;
    res.out_green = px.dst_green;
    res.out_blue  = px.dst_blue;
    res.out_alpha = px.dst_alpha;
    opacity = frac_mul(cel_opacity, layer_opacity);
    // zero opacity or zero source alpha keeps the destination
    if (opacity != 0 && px.src_alpha != 0) begin
      sa = frac_mul(px.src_alpha, opacity);
      ra = int'(px.dst_alpha) + int'(sa) - int'(frac_mul(px.dst_alpha, sa));
      // fully transparent result also keeps the destination
      if (ra != 0) begin
        res.out_red   = blend_chan(px.src_red, px.dst_red, sa, ra);
        res.out_green = blend_chan(px.src_green, px.dst_green, sa, ra);
        res.out_blue  = blend_chan(px.src_blue, px.dst_blue, sa, ra);
        res.out_alpha = ra[7:0];
      end
    end
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // channel value biased toward the ends of the range
  function automatic pix_t rand_chan();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r == 2) return pix_t'($urandom_range(1, 4));
    return pix_t'($urandom_range(0, 255));
  endfunction

  function automatic blend_in_t rand_pixel();
    blend_in_t px;
    px.src_red   = rand_chan();
    px.src_green = rand_chan();
    px.src_blue  = rand_chan();
    px.src_alpha = rand_chan();
    px.dst_red   = rand_chan();
    px.dst_green = rand_chan();
    px.dst_blue  = rand_chan();
    px.dst_alpha = rand_chan();
    return px;
  endfunction

  function automatic blend_in_t mk_pixel(input pix_t sr, input pix_t sg, input pix_t sb,
                                         input pix_t sa, input pix_t dr, input pix_t dg,
                                         input pix_t db, input pix_t da);
    return '{sr, sg, sb, sa, dr, dg, db, da};
  endfunction

  // offer one pixel pair and wait for the transaction
  task automatic send_pixel(input blend_in_t px);
    int gap;
    gap = tx_idle_en ? idle_len() : 0;
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_in.valid     <= 1'b1;
    pix_in.src_red   <= px.src_red;
    pix_in.src_green <= px.src_green;
    pix_in.src_blue  <= px.src_blue;
    pix_in.src_alpha <= px.src_alpha;
    pix_in.dst_red   <= px.dst_red;
    pix_in.dst_green <= px.dst_green;
    pix_in.dst_blue  <= px.dst_blue;
    pix_in.dst_alpha <= px.dst_alpha;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    blend_expected_q.insert(blend_expected_q.size(), predict_blend(px));
    pixels_sent++;
  endtask

  // stop offering and let the pipeline empty
  task automatic wait_idle();
    pix_in.valid <= 1'b0;
    while (blend_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // program both opacities while the block is idle
  task automatic set_opacity(input pix_t cel, input pix_t layer);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_CEL_ALPHA;
    cfg_wdata_i <= cel;
    @(posedge clk_i);
    cel_opacity = cel;
    cfg_idx_i   <= CFG_LAYER_ALPHA;
    cfg_wdata_i <= layer;
    @(posedge clk_i);
    layer_opacity = layer;
    cfg_we_i <= 1'b0;
    opacity_settings++;
  endtask

  task automatic check_field(input string field, input pix_t exp_v, input pix_t got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, got_v);
      err_count++;
    end
  endtask

  // output side: check each transaction, then pick the next ready
  initial begin
    blend_out_t got;
    blend_out_t exp_px;
    int len;
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pix_out.valid && pix_out.ready) begin
        got = '{pix_out.out_red, pix_out.out_green, pix_out.out_blue, pix_out.out_alpha};
        if (blend_expected_q.size() == 0) begin
          $error("unexpected output pixel r=%0d g=%0d b=%0d a=%0d",
                 got.out_red, got.out_green, got.out_blue, got.out_alpha);
          err_count++;
        end else begin
          exp_px = blend_expected_q.pop_front();
          check_field("out_red", exp_px.out_red, got.out_red);
          check_field("out_green", exp_px.out_green, got.out_green);
          check_field("out_blue", exp_px.out_blue, got.out_blue);
          check_field("out_alpha", exp_px.out_alpha, got.out_alpha);
          pixels_checked++;
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        pix_out.ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        pix_out.ready <= 1'b0;
      end else begin
        len = rx_idle_en ? idle_len() : 0;
        if (len > 0) begin
          rx_stall_left = len - 1;
          pix_out.ready <= 1'b0;
        end else begin
          pix_out.ready <= 1'b1;
        end
      end
    end
  end

  // corner pixels at full opacity (reset values)
  task automatic test_corner_pixels();
    send_pixel(mk_pixel(0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(mk_pixel(255, 255, 255, 255, 255, 255, 255, 255));
    send_pixel(mk_pixel(255, 255, 255, 255, 0, 0, 0, 255));
    send_pixel(mk_pixel(200, 10, 99, 0, 1, 2, 3, 4));
    send_pixel(mk_pixel(10, 20, 30, 128, 250, 240, 230, 0));
    send_pixel(mk_pixel(255, 0, 128, 128, 0, 255, 128, 128));
    send_pixel(mk_pixel(255, 255, 255, 1, 0, 0, 0, 0));
    send_pixel(mk_pixel(255, 0, 255, 1, 0, 255, 0, 255));
    send_pixel(mk_pixel(0, 0, 0, 254, 255, 255, 255, 1));
  endtask

  // either opacity at zero passes the destination through
  task automatic test_zero_opacity();
    set_opacity(8'd0, 8'd255);
    send_pixel(mk_pixel(255, 255, 255, 255, 12, 34, 56, 78));
    send_pixel(mk_pixel(0, 128, 255, 200, 255, 0, 128, 0));
    send_pixel(mk_pixel(90, 80, 70, 60, 50, 40, 30, 255));
    set_opacity(8'd255, 8'd0);
    send_pixel(mk_pixel(255, 255, 255, 255, 0, 0, 0, 0));
    send_pixel(mk_pixel(1, 2, 3, 255, 200, 201, 202, 203));
  endtask

  // opacity of one: effective alpha rounds to zero or one
  task automatic test_vanishing_alpha();
    set_opacity(8'd255, 8'd1);
    send_pixel(mk_pixel(255, 255, 255, 1, 9, 8, 7, 0));
    send_pixel(mk_pixel(255, 0, 255, 127, 0, 255, 0, 0));
    send_pixel(mk_pixel(255, 0, 255, 128, 0, 255, 0, 0));
    send_pixel(mk_pixel(255, 255, 255, 255, 0, 0, 0, 0));
  endtask

  // output held off while the input keeps offering
  task automatic test_output_backpressure();
    set_opacity(8'd180, 8'd230);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold_left = HoldCycles;
    repeat (PressureItems) send_pixel(rand_pixel());
  endtask

  // random pixels under a sweep of opacities and idling mixes
  task automatic test_random_blend();
    int cel_set[NumPhases] = '{255, 0, 255, 1, 128, 200, 255, 0, 0};
    int layer_set[NumPhases] = '{255, 255, 0, 255, 128, 77, 1, 0, 0};
    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph >= NumPhases - 2) begin
        cel_set[ph] = $urandom_range(0, 255);
        layer_set[ph] = $urandom_range(0, 255);
      end
      set_opacity(pix_t'(cel_set[ph]), pix_t'(layer_set[ph]));
      for (int n = 0; n < PhaseItems; n++) begin
        // first stretch of each phase runs back to back
        tx_idle_en = (n >= 20) && (ph % 3 != 1);
        rx_idle_en = (n >= 20) && (ph % 3 != 2);
        send_pixel(rand_pixel());
      end
    end
  endtask

  // main sequence
  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_CEL_ALPHA;
    cfg_wdata_i      <= '0;
    pix_in.valid     <= 1'b0;
    pix_in.src_red   <= '0;
    pix_in.src_green <= '0;
    pix_in.src_blue  <= '0;
    pix_in.src_alpha <= '0;
    pix_in.dst_red   <= '0;
    pix_in.dst_green <= '0;
    pix_in.dst_blue  <= '0;
    pix_in.dst_alpha <= '0;
    cel_opacity   = 8'd255;
    layer_opacity = 8'd255;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    rx_hold_left  = 0;
    rx_stall_left = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_pixels();
    test_zero_opacity();
    test_vanishing_alpha();
    test_output_backpressure();
    test_random_blend();
    wait_idle();

    $display("blended %0d pixel pairs, %0d outputs checked, %0d opacity settings",
             pixels_sent, pixels_checked, opacity_settings);
    $display("input held off for %0d cycles under output backpressure",
             input_stall_cycles);
    if (err_count == 0) begin
      $display("tb_alpha_over_blend_8bit: clean");
    end else begin
      $display("tb_alpha_over_blend_8bit: errors");
    end
    $finish;
  end

endmodule
